### hdl/dgcc_pkg.sv
// ----------------------------------------------------------------------------
// dgcc_pkg
// shared widths, command codes and register map of the dependency graph
// cycle checker
// ----------------------------------------------------------------------------
package dgcc_pkg;

  localparam int ROW_W  = 64;
  localparam int NODE_W = 6;
  localparam int ACT_W  = 3;
  localparam int CNT_W  = 7;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 3'd0,
    ACT_ADD   = 3'd1,
    ACT_MARK  = 3'd2,
    ACT_QUERY = 3'd3,
    ACT_CHECK = 3'd4
  } action_t;

  // register index, taken from paddr[2]
  localparam logic REG_NODE_COUNT = 1'b0;

endpackage

### hdl/dgcc_ifs.sv
// ----------------------------------------------------------------------------
// dgcc_ifs
// command and result channels of the dependency graph cycle checker
// ----------------------------------------------------------------------------
interface dgcc_cmd_if import dgcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [NODE_W-1:0] from_node;
  logic [NODE_W-1:0] to_node;
  logic [NODE_W-1:0] node_index;
  logic              use_mask;
  logic [ROW_W-1:0]  mask_bits;

  modport source (
    output valid, action, from_node, to_node, node_index, use_mask, mask_bits,
    input  ready
  );
  modport sink (
    input  valid, action, from_node, to_node, node_index, use_mask, mask_bits,
    output ready
  );
endinterface

interface dgcc_res_if ();
  logic valid;
  logic ready;
  logic accepted;
  logic governed_flag;
  logic cycle_found;

  modport source (output valid, accepted, governed_flag, cycle_found, input ready);
  modport sink   (input valid, accepted, governed_flag, cycle_found, output ready);
endinterface

### hdl/dgcc_ram.sv
// ----------------------------------------------------------------------------
// dgcc_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module dgcc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/dependency_graph_cycle_check_top.sv
// ----------------------------------------------------------------------------
// dependency_graph_cycle_check_top
// dependency graph store with governed marks and a warshall cycle check
// ----------------------------------------------------------------------------
// Commands arrive on in_cmd (valid/ready), one result beat per command leaves
// on out_res. node_count is to be written over the apb port at address 0 only
// while the block is idle; the user must keep to this, the block itself does
// not enforce it. pready is always high. Clear, mark, query, refused and
// unknown commands give their result beat in the cycle after acceptance. An
// added edge reads and then writes back one edge row before its result beat.
// A cycle check with N = min(node_count, MAX_NODES) runs one pass copying the
// masked edge rows into the closure ram, N closure passes over the closure
// ram read/write ports, and one pass testing the diagonal.
// One command is worked on at a time. A finished result sits in the output
// register; the next command is taken as soon as the machine is idle and that
// register is empty or being emptied, so a stalled receiver holds off input.
// Reset clears node_count, all edge rows (through per-row valid bits) and the
// governed marks; the closure ram needs no clearing.
// ----------------------------------------------------------------------------
module dependency_graph_cycle_check_top import dgcc_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  dgcc_cmd_if.sink          in_cmd,
  dgcc_res_if.source        out_res,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_NODES);

  typedef enum logic [3:0] {
    S_IDLE, S_COPY, S_COPY_END, S_LDK, S_GETK, S_SWEEP, S_SWEEP_END,
    S_CHECK, S_CHECK_END, S_DONE
  } state_t;

  typedef enum logic [1:0] {PK_EDGE, PK_COPY, PK_SWEEP, PK_CHECK} pend_t;

  state_t               st_r, st_nxt;
  logic [AW-1:0]        i_r, i_nxt;
  logic [AW-1:0]        k_r, k_nxt;
  logic [ROW_W-1:0]     rk_r, rk_nxt;
  logic [ROW_W-1:0]     sel_r, sel_nxt;
  logic                 p_vld_r, p_vld_nxt;
  pend_t                p_kind_r, p_kind_nxt;
  logic [AW-1:0]        p_idx_r, p_idx_nxt;
  logic [NODE_W-1:0]    to_r, to_nxt;
  logic                 found_r, found_nxt;
  logic [MAX_NODES-1:0] row_vld_r, row_vld_nxt;
  logic [ROW_W-1:0]     gov_r, gov_nxt;
  logic [CNT_W-1:0]     node_count_r, node_count_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 out_acc_r, out_acc_nxt;
  logic                 out_gov_r, out_gov_nxt;
  logic                 out_cyc_r, out_cyc_nxt;

  logic [CNT_W-1:0] n_act, n_last;
  logic             i_last, k_last, out_free, in_fire, out_load, cfg_wr;
  logic [ROW_W-1:0] edge_row;

  logic             e_we, c_we;
  logic [AW-1:0]    e_waddr, e_raddr, c_waddr, c_raddr;
  logic [ROW_W-1:0] e_wdata, e_rdata, c_wdata, c_rdata;

  dgcc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_edge_ram (
    .clk  (clk),
    .we   (e_we),
    .waddr(e_waddr),
    .wdata(e_wdata),
    .raddr(e_raddr),
    .rdata(e_rdata)
  );

  dgcc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_clos_ram (
    .clk  (clk),
    .we   (c_we),
    .waddr(c_waddr),
    .wdata(c_wdata),
    .raddr(c_raddr),
    .rdata(c_rdata)
  );

  assign n_act    = (node_count_r > MAX_N) ? MAX_N : node_count_r;
  assign n_last   = n_act - 1'b1;
  assign i_last   = (CNT_W'(i_r) == n_last);
  assign k_last   = (CNT_W'(k_r) == n_last);
  assign out_free = !out_vld_r || out_res.ready;
  assign in_cmd.ready = (st_r == S_IDLE) && out_free;
  assign in_fire  = in_cmd.valid && in_cmd.ready;
  assign edge_row = row_vld_r[p_idx_r] ? e_rdata : '0;

  assign out_res.valid         = out_vld_r;
  assign out_res.accepted      = out_acc_r;
  assign out_res.governed_flag = out_gov_r;
  assign out_res.cycle_found   = out_cyc_r;

  // apb register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_NODE_COUNT) ?
                      DATA_W'(node_count_r) : '0;

  always_comb begin
    st_nxt         = st_r;
    i_nxt          = i_r;
    k_nxt          = k_r;
    rk_nxt         = rk_r;
    sel_nxt        = sel_r;
    p_vld_nxt      = 1'b0;
    p_kind_nxt     = p_kind_r;
    p_idx_nxt      = p_idx_r;
    to_nxt         = to_r;
    found_nxt      = found_r;
    row_vld_nxt    = row_vld_r;
    gov_nxt        = gov_r;
    node_count_nxt = node_count_r;
    out_load       = 1'b0;
    out_acc_nxt    = out_acc_r;
    out_gov_nxt    = out_gov_r;
    out_cyc_nxt    = out_cyc_r;
    e_we           = 1'b0;
    e_waddr        = p_idx_r;
    e_wdata        = edge_row;
    e_raddr        = i_r;
    c_we           = 1'b0;
    c_waddr        = p_idx_r;
    c_wdata        = c_rdata;
    c_raddr        = i_r;

    if (cfg_wr && cfg_paddr[2] == REG_NODE_COUNT) begin
      node_count_nxt = cfg_pwdata[CNT_W-1:0];
    end

    // write back of the row read in the previous cycle
    if (p_vld_r) begin
      case (p_kind_r)
        PK_EDGE: begin
          e_we                 = 1'b1;
          e_wdata              = edge_row | (ROW_W'(1) << to_r);
          row_vld_nxt[p_idx_r] = 1'b1;
        end
        PK_COPY: begin
          c_we    = 1'b1;
          c_wdata = sel_r[p_idx_r] ? (edge_row & sel_r) : '0;
        end
        PK_SWEEP: begin
          if (c_rdata[k_r]) begin
            c_we    = 1'b1;
            c_wdata = c_rdata | rk_r;
          end
        end
        PK_CHECK: begin
          if (sel_r[p_idx_r] && c_rdata[p_idx_r]) begin
            found_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end

    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          out_load    = 1'b1;
          out_acc_nxt = 1'b0;
          out_gov_nxt = 1'b0;
          out_cyc_nxt = 1'b0;
          case (in_cmd.action)
            ACT_CLEAR: begin
              row_vld_nxt = '0;
              gov_nxt     = '0;
              out_acc_nxt = 1'b1;
            end
            ACT_ADD: begin
              if ({1'b0, in_cmd.from_node} < n_act && {1'b0, in_cmd.to_node} < n_act) begin
                out_load   = 1'b0;
                e_raddr    = in_cmd.from_node[AW-1:0];
                p_vld_nxt  = 1'b1;
                p_kind_nxt = PK_EDGE;
                p_idx_nxt  = in_cmd.from_node[AW-1:0];
                to_nxt     = in_cmd.to_node;
                found_nxt  = 1'b0;
                st_nxt     = S_DONE;
              end
            end
            ACT_MARK: begin
              if ({1'b0, in_cmd.node_index} < n_act) begin
                gov_nxt     = gov_r | (ROW_W'(1) << in_cmd.node_index);
                out_acc_nxt = 1'b1;
              end
            end
            ACT_QUERY: begin
              out_acc_nxt = 1'b1;
              out_gov_nxt = ({1'b0, in_cmd.node_index} < n_act) &&
                            gov_r[in_cmd.node_index];
            end
            ACT_CHECK: begin
              out_acc_nxt = 1'b1;
              if (n_act != '0) begin
                out_load  = 1'b0;
                sel_nxt   = in_cmd.use_mask ? in_cmd.mask_bits : '1;
                i_nxt     = '0;
                found_nxt = 1'b0;
                st_nxt    = S_COPY;
              end
            end
            default: ;
          endcase
        end
      end
      S_COPY: begin
        e_raddr    = i_r;
        p_vld_nxt  = 1'b1;
        p_kind_nxt = PK_COPY;
        p_idx_nxt  = i_r;
        if (i_last) begin
          st_nxt = S_COPY_END;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_COPY_END: begin
        k_nxt  = '0;
        st_nxt = S_LDK;
      end
      S_LDK: begin
        c_raddr = k_r;
        st_nxt  = S_GETK;
      end
      S_GETK: begin
        rk_nxt = c_rdata;
        i_nxt  = '0;
        st_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        c_raddr    = i_r;
        p_vld_nxt  = 1'b1;
        p_kind_nxt = PK_SWEEP;
        p_idx_nxt  = i_r;
        if (i_last) begin
          st_nxt = S_SWEEP_END;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_SWEEP_END: begin
        if (k_last) begin
          i_nxt  = '0;
          st_nxt = S_CHECK;
        end else begin
          k_nxt  = k_r + 1'b1;
          st_nxt = S_LDK;
        end
      end
      S_CHECK: begin
        c_raddr    = i_r;
        p_vld_nxt  = 1'b1;
        p_kind_nxt = PK_CHECK;
        p_idx_nxt  = i_r;
        if (i_last) begin
          st_nxt = S_CHECK_END;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_CHECK_END: begin
        st_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_acc_nxt = 1'b1;
          out_gov_nxt = 1'b0;
          out_cyc_nxt = found_r;
          st_nxt      = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      p_vld_r      <= 1'b0;
      row_vld_r    <= '0;
      gov_r        <= '0;
      node_count_r <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      p_vld_r      <= p_vld_nxt;
      row_vld_r    <= row_vld_nxt;
      gov_r        <= gov_nxt;
      node_count_r <= node_count_nxt;
      out_vld_r    <= out_vld_nxt;
    end
    i_r       <= i_nxt;
    k_r       <= k_nxt;
    rk_r      <= rk_nxt;
    sel_r     <= sel_nxt;
    p_kind_r  <= p_kind_nxt;
    p_idx_r   <= p_idx_nxt;
    to_r      <= to_nxt;
    found_r   <= found_nxt;
    out_acc_r <= out_acc_nxt;
    out_gov_r <= out_gov_nxt;
    out_cyc_r <= out_cyc_nxt;
  end

  // edge row write back only right after an accepted add edge
  a_edge_wb: assert property (@(posedge clk) disable iff (!rst_n)
    e_we |-> $past(in_fire && in_cmd.action == ACT_ADD))
    else $error("edge row written without an add edge command");

  // a new result never overwrites one still waiting
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_vld_r || out_res.ready))
    else $error("result register overwritten");

  // write back pending only while a command is in flight
  a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> st_r != S_IDLE)
    else $error("pending write back while idle");

  // a cycle is only reported for an accepted command
  a_cyc_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_acc_r || !out_cyc_r))
    else $error("cycle reported on a refused command");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dependency_graph_cycle_check_top.
// Commands go in on the input channel and results come back on the output
// channel, both with random idle gaps. node_count is rewritten over the apb
// port between phases, once the block has gone idle. A scoreboard keeps its
// own copy of the edge matrix and the governed marks. For cycle checks it
// works out the transitive closure, and it compares every result beat with
// the oldest expected result. The bench starts with directed commands (empty
// graph, self edge, refused indices, stale bits, masked checks, unknown
// actions). It then runs random command streams at several node counts,
// including zero and counts above the node limit.
// ----------------------------------------------------------------------------
module tb;
  import dgcc_pkg::*;

  localparam int NODE_LIMIT    = 64;
  localparam int MAX_WAIT      = 4;
  localparam int SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [NODE_W-1:0] node_index;
    logic              use_mask;
    logic [ROW_W-1:0]  mask_bits;
  } graph_cmd_t;

  typedef struct {
    logic accepted;
    logic governed_flag;
    logic cycle_found;
  } verdict_t;

  class graph_scoreboard;
    bit [ROW_W-1:0] edge_rows [NODE_LIMIT];
    bit [ROW_W-1:0] governed_marks;
    bit [CNT_W-1:0] node_count;
    verdict_t       pending_verdicts [$];
    int unsigned    fail_count;

    function void set_node_count(bit [CNT_W-1:0] value);
      node_count = value;
    endfunction

    function int unsigned active_nodes();
      return (node_count > NODE_LIMIT) ? NODE_LIMIT : node_count;
    endfunction

    // warshall closure over the selected rows, then look at the diagonal
    function bit reaches_itself(int unsigned n, logic use_mask, logic [ROW_W-1:0] mask);
      bit [ROW_W-1:0] reach [NODE_LIMIT];
      bit [ROW_W-1:0] sel;
      sel = use_mask ? mask : '1;
      for (int i = 0; i < n; i++)
        reach[i] = sel[i] ? (edge_rows[i] & sel) : '0;
      for (int k = 0; k < n; k++)
        for (int i = 0; i < n; i++)
          if (reach[i][k]) reach[i] |= reach[k];
      for (int i = 0; i < n; i++)
        if (sel[i] && reach[i][i]) return 1'b1;
      return 1'b0;
    endfunction

    function void take_command(graph_cmd_t c);
      verdict_t    want;
      int unsigned n;
      n = active_nodes();
      want = '{accepted: 1'b0, governed_flag: 1'b0, cycle_found: 1'b0};
      case (c.action)
        ACT_CLEAR: begin
          foreach (edge_rows[i]) edge_rows[i] = '0;
          governed_marks = '0;
          want.accepted = 1'b1;
        end
        ACT_ADD: begin
          if (c.from_node < n && c.to_node < n) begin
            edge_rows[c.from_node][c.to_node] = 1'b1;
            want.accepted = 1'b1;
          end
        end
        ACT_MARK: begin
          if (c.node_index < n) begin
            governed_marks[c.node_index] = 1'b1;
            want.accepted = 1'b1;
          end
        end
        ACT_QUERY: begin
          want.accepted = 1'b1;
          want.governed_flag = (c.node_index < n) && governed_marks[c.node_index];
        end
        ACT_CHECK: begin
          want.accepted = 1'b1;
          want.cycle_found = (n > 0) && reaches_itself(n, c.use_mask, c.mask_bits);
        end
        default: ;
      endcase
      pending_verdicts.push_back(want);
    endfunction

    function void compare_field(string field, logic want, logic seen);
      if (want !== seen) begin
        $error("%s: expected %0b, got %0b", field, want, seen);
        fail_count++;
      end
    endfunction

    function void check_verdict(verdict_t seen);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no command pending");
        fail_count++;
        return;
      end
      want = pending_verdicts.pop_front();
      compare_field("accepted", want.accepted, seen.accepted);
      compare_field("governed_flag", want.governed_flag, seen.governed_flag);
      compare_field("cycle_found", want.cycle_found, seen.cycle_found);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  dgcc_cmd_if cmd_if ();
  dgcc_res_if res_if ();

  graph_scoreboard graph_sb = new;
  bit              gap_on;
  bit              stall_on;
  int unsigned     cycle_count;

  dependency_graph_cycle_check_top #(.MAX_NODES(NODE_LIMIT)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_cmd      (cmd_if),
    .out_res     (res_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("dependency_graph_cycle_check_top regression: fail");
      $finish;
    end
  end

  function automatic graph_cmd_t make_cmd(logic [ACT_W-1:0] action, int unsigned from_node,
                                          int unsigned to_node, int unsigned node_index,
                                          logic use_mask, logic [ROW_W-1:0] mask_bits);
    graph_cmd_t c;
    c.action     = action;
    c.from_node  = NODE_W'(from_node);
    c.to_node    = NODE_W'(to_node);
    c.node_index = NODE_W'(node_index);
    c.use_mask   = use_mask;
    c.mask_bits  = mask_bits;
    return c;
  endfunction

  // mostly in range, now and then any index
  function automatic logic [NODE_W-1:0] pick_node(int unsigned n);
    if (n != 0 && $urandom_range(0, 9) != 0) return NODE_W'($urandom_range(0, n - 1));
    return NODE_W'($urandom_range(0, NODE_LIMIT - 1));
  endfunction

  function automatic graph_cmd_t random_cmd(bit [CNT_W-1:0] count);
    graph_cmd_t  c;
    int unsigned n;
    int unsigned pick;
    n = (count > NODE_LIMIT) ? NODE_LIMIT : count;
    pick = $urandom_range(0, 99);
    if (pick < 4)       c.action = ACT_CLEAR;
    else if (pick < 46) c.action = ACT_ADD;
    else if (pick < 56) c.action = ACT_MARK;
    else if (pick < 68) c.action = ACT_QUERY;
    else if (pick < 93) c.action = ACT_CHECK;
    else                c.action = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    c.from_node  = pick_node(n);
    c.to_node    = pick_node(n);
    c.node_index = pick_node(n);
    c.use_mask   = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: c.mask_bits = {$urandom, $urandom};
      1: c.mask_bits = {$urandom, $urandom} | {$urandom, $urandom};
      2: c.mask_bits = '1;
      default: c.mask_bits = ~(ROW_W'(1) << $urandom_range(0, ROW_W - 1));
    endcase
    return c;
  endfunction

  // called at a rising edge; leaves valid high after the beat is taken
  task automatic drive_cmd(input graph_cmd_t c);
    int unsigned gap;
    gap = gap_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.action     <= c.action;
    cmd_if.from_node  <= c.from_node;
    cmd_if.to_node    <= c.to_node;
    cmd_if.node_index <= c.node_index;
    cmd_if.use_mask   <= c.use_mask;
    cmd_if.mask_bits  <= c.mask_bits;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    graph_sb.take_command(c);
  endtask

  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (graph_sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input bit [CNT_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({REG_NODE_COUNT, 2'b00});
    cfg_pwdata  <= DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    graph_sb.set_node_count(value);
    @(posedge clk);
  endtask

  task automatic run_phase(input bit [CNT_W-1:0] count, input int unsigned items);
    settle();
    write_node_count(count);
    gap_on   = $urandom_range(0, 3) != 0;
    stall_on = $urandom_range(0, 3) != 0;
    repeat (items) drive_cmd(random_cmd(count));
  endtask

  initial begin : result_sink
    int unsigned stall;
    verdict_t    seen;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = stall_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      seen.accepted      = res_if.accepted;
      seen.governed_flag = res_if.governed_flag;
      seen.cycle_found   = res_if.cycle_found;
      graph_sb.check_verdict(seen);
    end
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    cmd_if.valid      <= 1'b0;
    cmd_if.action     <= ACT_CLEAR;
    cmd_if.from_node  <= '0;
    cmd_if.to_node    <= '0;
    cmd_if.node_index <= '0;
    cmd_if.use_mask   <= 1'b0;
    cmd_if.mask_bits  <= '0;
    gap_on   = 1'b1;
    stall_on = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty graph after reset
    drive_cmd(make_cmd(ACT_CHECK, 0, 0, 0, 1'b0, '0));
    drive_cmd(make_cmd(ACT_ADD, 0, 0, 0, 1'b0, '0));
    drive_cmd(make_cmd(ACT_MARK, 0, 0, 0, 1'b0, '0));
    drive_cmd(make_cmd(ACT_QUERY, 0, 0, 0, 1'b0, '0));
    drive_cmd(make_cmd(ACT_SPARE_HI, 63, 63, 63, 1'b1, '1));

    // full size: self edge, masks, clear, short loop
    settle();
    write_node_count(CNT_W'(NODE_LIMIT));
    drive_cmd(make_cmd(ACT_ADD, 63, 63, 0, 1'b0, '0));
    drive_cmd(make_cmd(ACT_CHECK, 0, 0, 0, 1'b0, '0));
    drive_cmd(make_cmd(ACT_MARK, 0, 0, 63, 1'b0, '0));
    drive_cmd(make_cmd(ACT_QUERY, 0, 0, 63, 1'b0, '0));
    drive_cmd(make_cmd(ACT_CHECK, 0, 0, 0, 1'b1, ~(ROW_W'(1) << 63)));
    drive_cmd(make_cmd(ACT_CLEAR, 63, 63, 63, 1'b1, '1));
    drive_cmd(make_cmd(ACT_QUERY, 0, 0, 63, 1'b0, '0));
    drive_cmd(make_cmd(ACT_ADD, 0, 1, 0, 1'b0, '0));
    drive_cmd(make_cmd(ACT_ADD, 1, 2, 0, 1'b0, '0));
    drive_cmd(make_cmd(ACT_ADD, 2, 0, 0, 1'b0, '0));
    drive_cmd(make_cmd(ACT_CHECK, 0, 0, 0, 1'b1, '1));
    drive_cmd(make_cmd(ACT_CHECK, 0, 0, 0, 1'b1, ROW_W'(3)));
    drive_cmd(make_cmd(ACT_CHECK, 0, 0, 0, 1'b1, '0));
    drive_cmd(make_cmd(ACT_MARK, 0, 0, 40, 1'b0, '0));
    drive_cmd(make_cmd(ACT_SPARE_LO, 0, 0, 0, 1'b0, '0));

    // small count: refused indices and stale marks
    settle();
    write_node_count(CNT_W'(3));
    drive_cmd(make_cmd(ACT_QUERY, 0, 0, 40, 1'b0, '0));
    drive_cmd(make_cmd(ACT_ADD, 5, 1, 0, 1'b0, '0));
    drive_cmd(make_cmd(ACT_MARK, 0, 0, 3, 1'b0, '0));
    drive_cmd(make_cmd(ACT_CHECK, 0, 0, 0, 1'b0, '0));

    // count above the node limit
    settle();
    write_node_count('1);
    drive_cmd(make_cmd(ACT_ADD, 63, 62, 0, 1'b0, '0));
    drive_cmd(make_cmd(ACT_QUERY, 0, 0, 40, 1'b0, '0));

    run_phase(CNT_W'(6), 16);
    run_phase(CNT_W'(12), 16);
    run_phase(CNT_W'(1), 6);
    run_phase(CNT_W'(20), 12);
    run_phase('1, 6);
    run_phase(CNT_W'(3), 12);
    run_phase(CNT_W'(0), 6);
    run_phase(CNT_W'(9), 16);
    run_phase(CNT_W'(40), 8);
    run_phase(CNT_W'(2), 8);
    run_phase(CNT_W'(16), 8);

    settle();
    if (graph_sb.fail_count == 0)
      $display("dependency_graph_cycle_check_top regression: pass");
    else
      $display("dependency_graph_cycle_check_top regression: fail");
    $finish;
  end

endmodule

### filelist.f
hdl/dgcc_pkg.sv
hdl/dgcc_ifs.sv
hdl/dgcc_ram.sv
hdl/dependency_graph_cycle_check_top.sv
bench/tb.sv
